### rtl/brm_pkg.sv
// Shared opcodes, status codes and the execute result record of the byte register machine.
package brm_pkg;

  localparam int unsigned NUM_REGS = 16;
  localparam int unsigned REG_AW   = $clog2(NUM_REGS);

  localparam logic [7:0] RX_MASK = 8'h0F;
  localparam logic [7:0] RY_MASK = 8'hF0;

  localparam logic [7:0] OP_INC   = 8'd1;
  localparam logic [7:0] OP_DEC   = 8'd2;
  localparam logic [7:0] OP_MOV   = 8'd3;
  localparam logic [7:0] OP_LDI   = 8'd4;
  localparam logic [7:0] OP_SHL   = 8'd5;
  localparam logic [7:0] OP_SHR   = 8'd6;
  localparam logic [7:0] OP_JMP   = 8'd7;
  localparam logic [7:0] OP_JFC   = 8'd8;
  localparam logic [7:0] OP_JFS_A = 8'd9;
  localparam logic [7:0] OP_JFS_B = 8'd10;
  localparam logic [7:0] OP_HALT  = 8'd11;
  localparam logic [7:0] OP_ADD   = 8'd12;
  localparam logic [7:0] OP_SUB   = 8'd13;
  localparam logic [7:0] OP_XOR   = 8'd14;
  localparam logic [7:0] OP_OR    = 8'd15;
  localparam logic [7:0] OP_IN    = 8'd16;
  localparam logic [7:0] OP_OUT   = 8'd17;

  localparam logic [1:0] ST_RUN   = 2'd0;
  localparam logic [1:0] ST_HALT  = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  localparam logic [8:0] PROG_LEN_MAX = 9'd256;

  typedef struct packed {
    logic              rf_we;
    logic [REG_AW-1:0] rf_waddr;
    logic [7:0]        rf_wdata;
    logic              end_flag_next;
    logic [7:0]        pc_next;
    logic [1:0]        stop_next;
    logic [7:0]        next_pc;
    logic              out_valid;
    logic [7:0]        out_byte;
    logic              in_consumed;
    logic [1:0]        run_status;
  } brm_exec_t;

endpackage

### rtl/brm_exec.sv
// Combinational execute step: register arithmetic, flag update and program counter update.
module brm_exec (
  input  logic [7:0]         opcode,
  input  logic [7:0]         operand,
  input  logic [7:0]         in_byte,
  input  logic               in_available,
  input  logic [7:0]         rx_data,
  input  logic [7:0]         ry_data,
  input  logic               end_flag,
  input  logic [7:0]         pc,
  input  logic [1:0]         stop_state,
  input  logic [8:0]         prog_len,
  output brm_pkg::brm_exec_t ex
);

  logic       take_jump;
  logic [9:0] pc_ext;
  logic [9:0] offset;
  logic [9:0] new_pc;
  logic [8:0] limit;
  logic       out_of_range;
  logic [7:0] rx_field;

  assign rx_field = operand & brm_pkg::RX_MASK;

  assign take_jump = (opcode == brm_pkg::OP_JMP)
                  || ((opcode == brm_pkg::OP_JFC) && !end_flag)
                  || (((opcode == brm_pkg::OP_JFS_A) || (opcode == brm_pkg::OP_JFS_B))
                      && end_flag);

  assign pc_ext = {2'b00, pc};
  assign offset = {{2{operand[7]}}, operand};
  assign new_pc = take_jump ? (pc_ext + offset) : (pc_ext + 10'd2);

  // Lengths above 256 saturate.
  assign limit = (prog_len > brm_pkg::PROG_LEN_MAX) ? brm_pkg::PROG_LEN_MAX : prog_len;
  assign out_of_range = new_pc[9] || (new_pc[8:0] >= limit);

  always_comb begin
    ex               = '0;
    ex.rf_waddr      = rx_field[brm_pkg::REG_AW-1:0];
    ex.rf_wdata      = rx_data;
    ex.end_flag_next = end_flag;
    ex.pc_next       = pc;
    ex.stop_next     = stop_state;
    ex.next_pc       = pc;
    ex.run_status    = stop_state;
    if (stop_state == brm_pkg::ST_RUN) begin
      unique case (opcode)
        brm_pkg::OP_INC: begin
          ex.rf_we    = 1'b1;
          ex.rf_wdata = rx_data + 8'd1;
        end
        brm_pkg::OP_DEC: begin
          ex.rf_we    = 1'b1;
          ex.rf_wdata = rx_data - 8'd1;
        end
        brm_pkg::OP_MOV: begin
          ex.rf_we    = 1'b1;
          ex.rf_wdata = ry_data;
        end
        brm_pkg::OP_LDI: begin
          ex.rf_we    = 1'b1;
          ex.rf_waddr = '0;
          ex.rf_wdata = operand;
        end
        brm_pkg::OP_SHL: begin
          ex.rf_we    = 1'b1;
          ex.rf_wdata = {rx_data[6:0], 1'b0};
        end
        brm_pkg::OP_SHR: begin
          ex.rf_we    = 1'b1;
          ex.rf_wdata = {1'b0, rx_data[7:1]};
        end
        brm_pkg::OP_ADD: begin
          ex.rf_we    = 1'b1;
          ex.rf_wdata = rx_data + ry_data;
        end
        brm_pkg::OP_SUB: begin
          ex.rf_we    = 1'b1;
          ex.rf_wdata = rx_data - ry_data;
        end
        brm_pkg::OP_XOR: begin
          ex.rf_we    = 1'b1;
          ex.rf_wdata = rx_data ^ ry_data;
        end
        brm_pkg::OP_OR: begin
          ex.rf_we    = 1'b1;
          ex.rf_wdata = rx_data | ry_data;
        end
        brm_pkg::OP_IN: begin
          // End of input sets the flag and leaves Rx alone.
          ex.end_flag_next = !in_available;
          ex.rf_we         = in_available;
          ex.rf_wdata      = in_byte;
          ex.in_consumed   = in_available;
        end
        brm_pkg::OP_OUT: begin
          ex.out_valid = 1'b1;
          ex.out_byte  = rx_data;
        end
        default: begin
        end
      endcase

      priority if (opcode == brm_pkg::OP_HALT) begin
        ex.stop_next  = brm_pkg::ST_HALT;
        ex.run_status = brm_pkg::ST_HALT;
      end else if (out_of_range) begin
        ex.stop_next  = brm_pkg::ST_RANGE;
        ex.run_status = brm_pkg::ST_RANGE;
        ex.next_pc    = '0;
      end else begin
        ex.pc_next = new_pc[7:0];
        ex.next_pc = new_pc[7:0];
      end
    end
  end

endmodule

### rtl/byte_register_machine_execute_core.sv
// Top level of the byte register machine execute core.
// Operands are read from the register file at the input transfer, and the execute
// step loads the result register. Throughput: one instruction per cycle while
// results are not stalled; the execute step is the only loop.
// Reset (rst, synchronous): registers read as zero, flag and counter clear,
// status running, program_length 256; the pipeline empties.
module byte_register_machine_execute_core (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_write,
  input  logic [8:0] cfg_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] opcode,
  input  logic [7:0] operand,
  input  logic [7:0] in_byte,
  input  logic       in_available,
  output logic       res_valid,
  input  logic       res_stall,
  output logic [7:0] next_pc,
  output logic       out_valid,
  output logic [7:0] out_byte,
  output logic       in_consumed,
  output logic [1:0] run_status
);

  logic [7:0] mem [brm_pkg::NUM_REGS];
  logic [brm_pkg::NUM_REGS-1:0] rf_vld;

  logic [8:0] prog_len;
  logic       end_flag;
  logic [7:0] pc;
  logic [1:0] stop_state;

  logic       s1_valid;
  logic [7:0] s1_opcode;
  logic [7:0] s1_operand;
  logic [7:0] s1_in_byte;
  logic       s1_in_available;
  logic [7:0] s1_rx_data;
  logic [7:0] s1_ry_data;

  logic       adv;
  logic       in_acc;
  logic       wr_en;
  logic [brm_pkg::REG_AW-1:0] rd_x;
  logic [brm_pkg::REG_AW-1:0] rd_y;
  logic [7:0] rx_field;
  logic [7:0] ry_field;

  brm_pkg::brm_exec_t ex;

  assign adv      = s1_valid && !(res_valid && res_stall);
  assign in_stall = s1_valid && !adv;
  assign in_acc   = in_valid && !in_stall;
  assign wr_en    = adv && ex.rf_we;

  assign rx_field = operand & brm_pkg::RX_MASK;
  assign ry_field = (operand & brm_pkg::RY_MASK) >> 4;
  assign rd_x     = rx_field[brm_pkg::REG_AW-1:0];
  assign rd_y     = ry_field[brm_pkg::REG_AW-1:0];

  brm_exec u_exec (
    .opcode       (s1_opcode),
    .operand      (s1_operand),
    .in_byte      (s1_in_byte),
    .in_available (s1_in_available),
    .rx_data      (s1_rx_data),
    .ry_data      (s1_ry_data),
    .end_flag     (end_flag),
    .pc           (pc),
    .stop_state   (stop_state),
    .prog_len     (prog_len),
    .ex           (ex)
  );

  // Register file storage; unwritten entries read as zero through the valid bits.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[ex.rf_waddr] <= ex.rf_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rf_vld <= '0;
    end else if (wr_en) begin
      rf_vld[ex.rf_waddr] <= 1'b1;
    end
  end

  // Operand read with bypass from the instruction retiring in the same cycle.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_opcode       <= opcode;
      s1_operand      <= operand;
      s1_in_byte      <= in_byte;
      s1_in_available <= in_available;
      if (wr_en && (ex.rf_waddr == rd_x)) begin
        s1_rx_data <= ex.rf_wdata;
      end else begin
        s1_rx_data <= rf_vld[rd_x] ? mem[rd_x] : 8'd0;
      end
      if (wr_en && (ex.rf_waddr == rd_y)) begin
        s1_ry_data <= ex.rf_wdata;
      end else begin
        s1_ry_data <= rf_vld[rd_y] ? mem[rd_y] : 8'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_acc) begin
      s1_valid <= 1'b1;
    end else if (adv) begin
      s1_valid <= 1'b0;
    end
  end

  // Counter, flag and stop state advance on retire; cfg_write loads the program length.
  always_ff @(posedge clk) begin
    if (rst) begin
      prog_len   <= brm_pkg::PROG_LEN_MAX;
      end_flag   <= 1'b0;
      pc         <= '0;
      stop_state <= brm_pkg::ST_RUN;
    end else begin
      if (cfg_write) begin
        prog_len <= cfg_data;
      end
      if (adv) begin
        end_flag   <= ex.end_flag_next;
        pc         <= ex.pc_next;
        stop_state <= ex.stop_next;
      end
    end
  end

  // Result register; hold while stalled.
  always_ff @(posedge clk) begin
    if (adv) begin
      next_pc     <= ex.next_pc;
      out_valid   <= ex.out_valid;
      out_byte    <= ex.out_byte;
      in_consumed <= ex.in_consumed;
      run_status  <= ex.run_status;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (adv) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

`ifndef SYNTHESIS
  a_stop_sticky: assert property (@(posedge clk) disable iff (rst)
    (stop_state != brm_pkg::ST_RUN) |=> (stop_state == $past(stop_state)))
    else $error("stop state left after stopping");

  a_retire_result: assert property (@(posedge clk) disable iff (rst)
    adv |=> res_valid)
    else $error("retired instruction produced no result");

  a_no_write_stopped: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (stop_state == brm_pkg::ST_RUN))
    else $error("register write while stopped");

  a_out_in_exclusive: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> !(out_valid && in_consumed))
    else $error("output and input transfer in one result");
`endif

endmodule

### bench/brm_exec_checker.sv
// Checker for the byte register machine execute core: predicts each instruction's result.
`timescale 1ns / 1ps
module brm_exec_checker (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_write,
  input  logic [8:0] cfg_data,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic [7:0] opcode,
  input  logic [7:0] operand,
  input  logic [7:0] in_byte,
  input  logic       in_available,
  input  logic       res_valid,
  input  logic       res_stall,
  input  logic [7:0] next_pc,
  input  logic       out_valid,
  input  logic [7:0] out_byte,
  input  logic       in_consumed,
  input  logic [1:0] run_status,
  output int         pending,
  output int         failures
);

  typedef struct packed {
    logic [7:0] next_pc;
    logic       out_valid;
    logic [7:0] out_byte;
    logic       in_consumed;
    logic [1:0] run_status;
  } retire_t;

  // Architectural state as the core should see it
  logic [7:0] gpr [brm_pkg::NUM_REGS];
  logic       eof_flag;
  logic [7:0] pc_now;
  logic [1:0] stop_now;
  logic [8:0] prog_len;

  retire_t retire_q [$];
  int      mismatches = 0;

  function automatic retire_t retire_instr(logic [7:0] op, logic [7:0] opd,
                                           logic [7:0] ib, logic avail);
    retire_t    r;
    logic [3:0] rx;
    logic [3:0] ry;
    logic       taken;
    int         limit;
    int         target;
    r     = '0;
    rx    = 4'(opd & brm_pkg::RX_MASK);
    ry    = 4'((opd & brm_pkg::RY_MASK) >> 4);
    taken = 1'b0;
    // Once stopped, the core only echoes the held counter and status
    if (stop_now != brm_pkg::ST_RUN) begin
      r.next_pc    = pc_now;
      r.run_status = stop_now;
      return r;
    end
    case (op)
      brm_pkg::OP_INC:   gpr[rx] = gpr[rx] + 8'd1;
      brm_pkg::OP_DEC:   gpr[rx] = gpr[rx] - 8'd1;
      brm_pkg::OP_MOV:   gpr[rx] = gpr[ry];
      brm_pkg::OP_LDI:   gpr[0] = opd;
      brm_pkg::OP_SHL:   gpr[rx] = gpr[rx] << 1;
      brm_pkg::OP_SHR:   gpr[rx] = gpr[rx] >> 1;
      brm_pkg::OP_JMP:   taken = 1'b1;
      brm_pkg::OP_JFC:   taken = !eof_flag;
      brm_pkg::OP_JFS_A, brm_pkg::OP_JFS_B: taken = eof_flag;
      brm_pkg::OP_HALT:  stop_now = brm_pkg::ST_HALT;
      brm_pkg::OP_ADD:   gpr[rx] = gpr[rx] + gpr[ry];
      brm_pkg::OP_SUB:   gpr[rx] = gpr[rx] - gpr[ry];
      brm_pkg::OP_XOR:   gpr[rx] = gpr[rx] ^ gpr[ry];
      brm_pkg::OP_OR:    gpr[rx] = gpr[rx] | gpr[ry];
      brm_pkg::OP_IN: begin
        if (avail) begin
          eof_flag      = 1'b0;
          gpr[rx]       = ib;
          r.in_consumed = 1'b1;
        end else begin
          eof_flag = 1'b1;
        end
      end
      brm_pkg::OP_OUT: begin
        r.out_valid = 1'b1;
        r.out_byte  = gpr[rx];
      end
      default: ;
    endcase
    // Halt holds the counter on the halt instruction itself
    if (stop_now == brm_pkg::ST_HALT) begin
      r.next_pc    = pc_now;
      r.run_status = brm_pkg::ST_HALT;
      return r;
    end
    limit  = (prog_len > brm_pkg::PROG_LEN_MAX) ? int'(brm_pkg::PROG_LEN_MAX)
                                                : int'(prog_len);
    target = taken ? int'(pc_now) + int'($signed(opd)) : int'(pc_now) + 2;
    if (target < 0 || target >= limit) begin
      // Out of range: report zero, keep the old counter
      stop_now  = brm_pkg::ST_RANGE;
      r.next_pc = '0;
    end else begin
      pc_now    = 8'(target);
      r.next_pc = pc_now;
    end
    r.run_status = stop_now;
    return r;
  endfunction

  task automatic compare_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      mismatches++;
      $error("%s mismatch: expected %0h, got %0h", name, want, got);
    end
  endtask

  always @(posedge clk) begin
    retire_t want;
    if (rst) begin
      for (int k = 0; k < brm_pkg::NUM_REGS; k++) gpr[k] = '0;
      eof_flag = 1'b0;
      pc_now   = '0;
      stop_now = brm_pkg::ST_RUN;
      prog_len = brm_pkg::PROG_LEN_MAX;
      retire_q.delete();
    end else begin
      if (cfg_write) prog_len = cfg_data;
      if (in_valid && !in_stall)
        retire_q.push_back(retire_instr(opcode, operand, in_byte, in_available));
      if (res_valid && !res_stall) begin
        if (retire_q.size() == 0) begin
          mismatches++;
          $error("result transfer with no instruction outstanding, next_pc %0h", next_pc);
        end else begin
          want = retire_q.pop_front();
          compare_field("next_pc", want.next_pc, next_pc);
          compare_field("out_valid", 8'(want.out_valid), 8'(out_valid));
          compare_field("out_byte", want.out_byte, out_byte);
          compare_field("in_consumed", 8'(want.in_consumed), 8'(in_consumed));
          compare_field("run_status", 8'(want.run_status), 8'(run_status));
        end
      end
    end
    pending  <= retire_q.size();
    failures <= mismatches;
  end

endmodule

### bench/byte_register_machine_execute_core_test.sv
// Stimulus and verdict for the byte register machine execute core.
`timescale 1ns / 1ps
module byte_register_machine_execute_core_test;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int LONG_HOLD      = 80;
  localparam int PHASE_ITEMS    = 140;
  localparam int SHORT_ITEMS    = 50;
  localparam int FULL_SPAN      = 256;

  localparam logic [7:0] OP_NOP        = 8'd0;
  localparam logic [7:0] OP_UNUSED_LOW = brm_pkg::OP_OUT + 8'd1;

  logic       clk          = 1'b0;
  logic       rst          = 1'b1;
  logic       cfg_write    = 1'b0;
  logic [8:0] cfg_data     = '0;
  logic       in_valid     = 1'b0;
  logic [7:0] opcode       = '0;
  logic [7:0] operand      = '0;
  logic [7:0] in_byte      = '0;
  logic       in_available = 1'b0;
  logic       res_stall    = 1'b0;

  logic       in_stall;
  logic       res_valid;
  logic [7:0] next_pc;
  logic       out_valid;
  logic [7:0] out_byte;
  logic       in_consumed;
  logic [1:0] run_status;
  int         pending;
  int         failures;

  // Control flow as seen by the stimulus, used to keep the program in range
  int track_pc      = 0;
  int track_lim     = FULL_SPAN;
  bit track_eof     = 1'b0;
  bit track_stopped = 1'b0;

  bit sender_quiet  = 1'b0;
  bit hold_off_req  = 1'b0;
  int idle_cycles   = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  byte_register_machine_execute_core dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .opcode       (opcode),
    .operand      (operand),
    .in_byte      (in_byte),
    .in_available (in_available),
    .res_valid    (res_valid),
    .res_stall    (res_stall),
    .next_pc      (next_pc),
    .out_valid    (out_valid),
    .out_byte     (out_byte),
    .in_consumed  (in_consumed),
    .run_status   (run_status)
  );

  brm_exec_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .opcode       (opcode),
    .operand      (operand),
    .in_byte      (in_byte),
    .in_available (in_available),
    .res_valid    (res_valid),
    .res_stall    (res_stall),
    .next_pc      (next_pc),
    .out_valid    (out_valid),
    .out_byte     (out_byte),
    .in_consumed  (in_consumed),
    .run_status   (run_status),
    .pending      (pending),
    .failures     (failures)
  );

  // Mostly short gaps, a few long ones
  function automatic int pick_gap(bit quiet);
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic logic [7:0] alu_opcode();
    case ($urandom_range(0, 9))
      0:       return brm_pkg::OP_INC;
      1:       return brm_pkg::OP_DEC;
      2:       return brm_pkg::OP_MOV;
      3:       return brm_pkg::OP_LDI;
      4:       return brm_pkg::OP_SHL;
      5:       return brm_pkg::OP_SHR;
      6:       return brm_pkg::OP_ADD;
      7:       return brm_pkg::OP_SUB;
      8:       return brm_pkg::OP_XOR;
      default: return brm_pkg::OP_OR;
    endcase
  endfunction

  function automatic logic [7:0] unused_opcode();
    if ($urandom_range(0, 9) == 0) return OP_NOP;
    return 8'($urandom_range(int'(OP_UNUSED_LOW), 255));
  endfunction

  function automatic void track_item(logic [7:0] op, logic [7:0] opd, logic av);
    bit taken;
    int target;
    if (track_stopped) return;
    taken = (op == brm_pkg::OP_JMP) || (op == brm_pkg::OP_JFC && !track_eof) ||
            ((op == brm_pkg::OP_JFS_A || op == brm_pkg::OP_JFS_B) && track_eof);
    if (op == brm_pkg::OP_IN) track_eof = !av;
    if (op == brm_pkg::OP_HALT) begin
      track_stopped = 1'b1;
      return;
    end
    target = taken ? track_pc + int'($signed(opd)) : track_pc + 2;
    if (target < 0 || target >= track_lim) track_stopped = 1'b1;
    else track_pc = target;
  endfunction

  // Any target within the offset reach and the program
  function automatic int jump_target();
    int lo;
    int hi;
    lo = (track_pc > 128) ? track_pc - 128 : 0;
    hi = (track_pc + 127 < track_lim - 1) ? track_pc + 127 : track_lim - 1;
    return $urandom_range(hi, lo);
  endfunction

  task automatic send_item(logic [7:0] op, logic [7:0] opd, logic [7:0] ib, logic av);
    int gap;
    gap = pick_gap(sender_quiet);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    opcode       <= op;
    operand      <= opd;
    in_byte      <= ib;
    in_available <= av;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    track_item(op, opd, av);
  endtask

  // Taken jump, conditional when the flag allows it
  task automatic jump_to(int target);
    logic [7:0] op;
    if (track_eof) begin
      case ($urandom_range(0, 2))
        0:       op = brm_pkg::OP_JMP;
        1:       op = brm_pkg::OP_JFS_A;
        default: op = brm_pkg::OP_JFS_B;
      endcase
    end else begin
      op = ($urandom_range(0, 1) != 0) ? brm_pkg::OP_JMP : brm_pkg::OP_JFC;
    end
    send_item(op, 8'(target - track_pc), 8'($urandom), 1'($urandom));
  endtask

  task automatic steer_home();
    while (track_pc != 0) jump_to((track_pc > 128) ? track_pc - 128 : 0);
  endtask

  task automatic send_random();
    int         pick;
    logic [7:0] opd;
    logic [7:0] ib;
    opd = 8'($urandom);
    ib  = 8'($urandom);
    if (track_pc + 2 >= track_lim) begin
      jump_to(jump_target());
      return;
    end
    pick = $urandom_range(0, 99);
    if (pick < 45) send_item(alu_opcode(), opd, ib, 1'($urandom));
    else if (pick < 57) send_item(brm_pkg::OP_IN, opd, ib, $urandom_range(0, 4) != 0);
    else if (pick < 67) send_item(brm_pkg::OP_OUT, opd, ib, 1'($urandom));
    else if (pick < 77) jump_to(jump_target());
    else if (pick < 87) begin
      // Conditional jump that falls through; any offset
      if (!track_eof)
        send_item(($urandom_range(0, 1) != 0) ? brm_pkg::OP_JFS_A : brm_pkg::OP_JFS_B,
                  opd, ib, 1'($urandom));
      else send_item(brm_pkg::OP_JFC, opd, ib, 1'($urandom));
    end else send_item(unused_opcode(), opd, ib, 1'($urandom));
  endtask

  // Hold the sender until every outstanding result has arrived
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic set_length(logic [8:0] value);
    drain();
    cfg_data  <= value;
    cfg_write <= 1'b1;
    @(posedge clk);
    cfg_write <= 1'b0;
    track_lim = (value > brm_pkg::PROG_LEN_MAX) ? FULL_SPAN : int'(value);
  endtask

  initial begin : receiver
    bit stall_now;
    bit quiet;
    bit long_done;
    int n;
    int span;
    long_done = 1'b0;
    quiet     = 1'b0;
    span      = 0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_off_req && !long_done) begin
        long_done = 1'b1;
        stall_now = 1'b1;
        n         = LONG_HOLD;
      end else begin
        if (span <= 0) begin
          quiet = ($urandom_range(0, 3) == 0);
          span  = 150;
        end
        n         = pick_gap(quiet);
        stall_now = (n > 0);
        if (!stall_now) n = $urandom_range(1, 6);
      end
      res_stall <= stall_now;
      repeat (n) @(posedge clk);
      span -= n;
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (res_valid && !res_stall) || cfg_write)
      idle_cycles <= 0;
    else if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end else
      idle_cycles <= idle_cycles + 1;
  end

  initial begin : stimulus
    logic [8:0] new_len;
    int         new_lim;
    int         count;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Length above the full span saturates
    set_length(9'h1FF);

    // Directed: every operation but halt, wraparound, end of input, jumps both ways
    send_item(brm_pkg::OP_LDI,   8'hFF, 8'h00, 1'b1);
    send_item(brm_pkg::OP_INC,   8'hF0, 8'h00, 1'b1);
    send_item(brm_pkg::OP_DEC,   8'h01, 8'h00, 1'b1);
    send_item(brm_pkg::OP_MOV,   8'h1F, 8'h00, 1'b1);
    send_item(brm_pkg::OP_SHL,   8'h0F, 8'h00, 1'b1);
    send_item(brm_pkg::OP_SHR,   8'h0F, 8'h00, 1'b1);
    send_item(brm_pkg::OP_IN,    8'h02, 8'hA5, 1'b1);
    send_item(brm_pkg::OP_ADD,   8'h12, 8'h00, 1'b1);
    send_item(brm_pkg::OP_SUB,   8'hF2, 8'h00, 1'b1);
    send_item(brm_pkg::OP_XOR,   8'h22, 8'h00, 1'b1);
    send_item(brm_pkg::OP_OR,    8'h1F, 8'h00, 1'b1);
    send_item(brm_pkg::OP_OUT,   8'h0F, 8'h00, 1'b1);
    send_item(brm_pkg::OP_OUT,   8'h02, 8'h00, 1'b1);
    send_item(brm_pkg::OP_IN,    8'h03, 8'hFF, 1'b0);
    send_item(brm_pkg::OP_JFC,   8'h80, 8'h00, 1'b1);
    send_item(brm_pkg::OP_JFS_A, 8'h04, 8'h00, 1'b1);
    send_item(brm_pkg::OP_JFS_B, 8'hFE, 8'h00, 1'b1);
    send_item(brm_pkg::OP_IN,    8'h0E, 8'h00, 1'b1);
    send_item(brm_pkg::OP_JFS_A, 8'h7F, 8'h00, 1'b1);
    send_item(brm_pkg::OP_JFC,   8'h06, 8'h00, 1'b1);
    send_item(brm_pkg::OP_JMP,   8'h7F, 8'h00, 1'b1);
    send_item(brm_pkg::OP_JMP,   8'h80, 8'h00, 1'b1);
    send_item(brm_pkg::OP_JMP,   8'h00, 8'h00, 1'b1);
    send_item(OP_NOP,            8'h00, 8'h00, 1'b0);
    send_item(8'hFF,             8'hFF, 8'hFF, 1'b1);

    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0:       new_len = brm_pkg::PROG_LEN_MAX;
        1:       new_len = 9'($urandom_range(130, 256));
        2:       new_len = 9'($urandom_range(1, 12));
        3:       new_len = 9'($urandom_range(257, 511));
        default: new_len = 9'($urandom_range(130, 255));
      endcase
      new_lim = (new_len > brm_pkg::PROG_LEN_MAX) ? FULL_SPAN : int'(new_len);
      if (track_pc >= new_lim) steer_home();
      set_length(new_len);
      count = (ph == 2) ? SHORT_ITEMS : PHASE_ITEMS;
      for (int i = 0; i < count; i++) begin
        if (i % 40 == 0) sender_quiet = ($urandom_range(0, 3) == 0);
        // Long receiver hold while items keep coming
        if (ph == 0 && i == 10) begin
          sender_quiet = 1'b1;
          hold_off_req = 1'b1;
        end
        send_random();
      end
    end
    sender_quiet = 1'b0;

    // Stop the machine one way or another, then check that it stays stopped
    drain();
    case ($urandom_range(0, 3))
      0: send_item(brm_pkg::OP_HALT, 8'($urandom), 8'($urandom), 1'($urandom));
      1: begin
        set_length(9'(track_pc + 2));
        send_item(alu_opcode(), 8'($urandom), 8'($urandom), 1'($urandom));
      end
      2: begin
        steer_home();
        send_item(brm_pkg::OP_JMP, 8'($urandom_range(128, 255)), 8'($urandom),
                  1'($urandom));
      end
      default: begin
        set_length('0);
        send_item(alu_opcode(), 8'($urandom), 8'($urandom), 1'($urandom));
      end
    endcase
    set_length('0);
    repeat (12) send_item(8'($urandom), 8'($urandom), 8'($urandom), 1'($urandom));

    drain();
    repeat (8) @(posedge clk);
    if (failures == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
